[rtl/core/ifhg_pkg.sv]
// ----------------------------------------------------------------------------
// ifhg_pkg
// Types, constants and helpers shared by the IPv4 fragment header generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ifhg_pkg;

    localparam int FPS_W   = 11;
    localparam int TTL_W   = 8;
    localparam int LEN_W   = 16;
    localparam int IDX_W   = 6;
    localparam int OFF_W   = 13;
    localparam int TOT_W   = 11;
    localparam int CKS_W   = 16;
    localparam int CFG_IDX_W = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAG_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TTL       = 1'd1;

    localparam logic [FPS_W-1:0] FPS_RESET = 11'd1480;
    localparam logic [TTL_W-1:0] TTL_RESET = 8'd64;
    localparam logic [FPS_W-1:0] FPS_MIN   = 11'd1040;
    localparam logic [FPS_W-1:0] FPS_MAX   = 11'd1480;
    localparam logic [TOT_W-1:0] HDR_BYTES = 11'd20;
    localparam logic [IDX_W-1:0] IDX_LAST  = 6'd63;

    // version 4, header length 5 words, type of service 0
    localparam logic [15:0] VER_IHL_TOS = 16'h4500;

    typedef struct packed {
        logic [15:0] payload_length;
        logic [15:0] identification;
        logic [7:0]  protocol;
        logic [31:0] source_address;
        logic [31:0] destination_address;
    } desc_t;

    typedef struct packed {
        logic [IDX_W-1:0] fragment_index;
        logic [OFF_W-1:0] frag_offset;
        logic [TOT_W-1:0] total_len;
        logic             more_fragments;
        logic [CKS_W-1:0] header_checksum;
        logic             last;
    } hdr_t;

    // header words that feed the checksum unit
    typedef struct packed {
        logic [TOT_W-1:0] total_len;
        logic [15:0]      identification;
        logic [15:0]      flags_offset;
        logic [TTL_W-1:0] ttl;
        logic [7:0]       protocol;
        logic [31:0]      source_address;
        logic [31:0]      destination_address;
    } cks_hdr_t;

    function automatic logic [FPS_W-1:0] frag_size(input logic [FPS_W-1:0] v);
        logic [FPS_W-1:0] s;
        s = v;
        if (s < FPS_MIN) s = FPS_MIN;
        if (s > FPS_MAX) s = FPS_MAX;
        return {s[FPS_W-1:3], 3'b000};
    endfunction

endpackage

`default_nettype wire

[rtl/core/ifhg_cks.sv]
// ----------------------------------------------------------------------------
// ifhg_cks
// Iterative ones'-complement header checksum: one 16-bit word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ifhg_cks
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire ifhg_pkg::cks_hdr_t hdr,
    output      logic              done,
    output      logic [15:0]       checksum
);
    import ifhg_pkg::*;

    localparam int NWORDS = 9;
    localparam logic [3:0] W_LAST = 4'(NWORDS - 1);

    localparam logic [3:0] W_VER   = 4'd0;
    localparam logic [3:0] W_TOT   = 4'd1;
    localparam logic [3:0] W_ID    = 4'd2;
    localparam logic [3:0] W_FLAGS = 4'd3;
    localparam logic [3:0] W_TTL   = 4'd4;
    localparam logic [3:0] W_SRCH  = 4'd5;
    localparam logic [3:0] W_SRCL  = 4'd6;
    localparam logic [3:0] W_DSTH  = 4'd7;
    localparam logic [3:0] W_DSTL  = 4'd8;

    logic        busy_reg, busy_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] word;
    logic [16:0] sum;

    always_comb
    begin
        case (cnt_reg)
            W_VER:   word = VER_IHL_TOS;
            W_TOT:   word = {5'd0, hdr.total_len};
            W_ID:    word = hdr.identification;
            W_FLAGS: word = hdr.flags_offset;
            W_TTL:   word = {hdr.ttl, hdr.protocol};
            W_SRCH:  word = hdr.source_address[31:16];
            W_SRCL:  word = hdr.source_address[15:0];
            W_DSTH:  word = hdr.destination_address[31:16];
            W_DSTL:  word = hdr.destination_address[15:0];
            default: word = 16'd0;
        endcase
    end

    // end-around carry add
    assign sum = {1'b0, acc_reg} + {1'b0, word};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 4'd0;
            acc_next  = 16'd0;
        end
        else if (busy_reg)
        begin
            acc_next = sum[15:0] + {15'd0, sum[16]};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == W_LAST)
                busy_next = 1'b0;
        end
    end

    assign done     = busy_reg && (cnt_reg == W_LAST);
    assign checksum = ~acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule

`default_nettype wire

[rtl/core/ipv4_fragment_header_generator_unit.sv]
// ----------------------------------------------------------------------------
// ipv4_fragment_header_generator_unit
// Cuts one datagram descriptor into fragments and emits one IPv4 header each.
// ----------------------------------------------------------------------------
// Usage:
//   desc channel (desc_valid/desc_stall/desc): one datagram descriptor per
//   item. desc_stall is high from acceptance until the last header of that
//   datagram has been taken.
//   hdr channel (hdr_valid/hdr_stall/hdr): one header item per fragment, in
//   order, the last one flagged by hdr.last.
//   cfg port (cfg_we/cfg_index/cfg_data): fragment payload size and TTL;
//   write only while idle.
// Timing: each fragment passes a length step (ST_CALC), the checksum words
//   through the shared adder (ST_SUM) and an output step (ST_OUT), plus any
//   time hdr_stall holds the output; the single checksum adder sets the pace.
// Reset: returns to idle with fragment size 1480 and TTL 64.
// A stalled header item holds its value until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_fragment_header_generator_unit
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       desc_valid,
    output      logic                       desc_stall,
    input  wire ifhg_pkg::desc_t            desc,
    output      logic                       hdr_valid,
    input  wire logic                       hdr_stall,
    output      ifhg_pkg::hdr_t             hdr,
    input  wire logic                       cfg_we,
    input  wire logic [ifhg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ifhg_pkg::FPS_W-1:0] cfg_data
);
    import ifhg_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [FPS_W-1:0] fps_reg, fps_next;
    logic [TTL_W-1:0] ttl_reg, ttl_next;

    desc_t            desc_reg, desc_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    logic [LEN_W-1:0] offs_reg, offs_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [FPS_W-1:0] fs_reg, fs_next;
    logic [FPS_W-1:0] chunk_reg, chunk_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic             mf_reg, mf_next;
    logic             final_reg, final_next;
    logic [CKS_W-1:0] cks_reg, cks_next;

    logic [FPS_W-1:0] chunk_c;
    logic             final_c;
    logic             desc_acc;
    logic             cks_start;
    logic             cks_done;
    cks_hdr_t         cks_hdr;
    logic [CKS_W-1:0] cks_val;

    assign desc_stall = (state_reg != ST_IDLE);
    assign hdr_valid  = (state_reg == ST_OUT);
    assign desc_acc   = desc_valid && !desc_stall;

    assign final_c = (remain_reg <= {5'd0, fs_reg});
    assign chunk_c = (remain_reg < {5'd0, fs_reg}) ? remain_reg[FPS_W-1:0] : fs_reg;

    assign cks_start = (state_reg == ST_CALC);

    always_comb
    begin
        cks_hdr.total_len           = total_reg;
        cks_hdr.identification      = desc_reg.identification;
        cks_hdr.flags_offset        = {2'b00, mf_reg, offs_reg[LEN_W-1:3]};
        cks_hdr.ttl                 = ttl_reg;
        cks_hdr.protocol            = desc_reg.protocol;
        cks_hdr.source_address      = desc_reg.source_address;
        cks_hdr.destination_address = desc_reg.destination_address;
    end

    ifhg_cks u_cks
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cks_start),
        .hdr      (cks_hdr),
        .done     (cks_done),
        .checksum (cks_val)
    );

    always_comb
    begin
        state_next  = state_reg;
        fps_next    = fps_reg;
        ttl_next    = ttl_reg;
        desc_next   = desc_reg;
        remain_next = remain_reg;
        offs_next   = offs_reg;
        idx_next    = idx_reg;
        fs_next     = fs_reg;
        chunk_next  = chunk_reg;
        total_next  = total_reg;
        mf_next     = mf_reg;
        final_next  = final_reg;
        cks_next    = cks_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAG_SIZE: fps_next = cfg_data;
                REG_TTL:       ttl_next = cfg_data[TTL_W-1:0];
                default:       ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (desc_acc)
                begin
                    desc_next   = desc;
                    remain_next = desc.payload_length;
                    offs_next   = '0;
                    idx_next    = '0;
                    fs_next     = frag_size(fps_reg);
                    state_next  = ST_CALC;
                end
            end
            ST_CALC:
            begin
                chunk_next = chunk_c;
                final_next = final_c;
                mf_next    = !final_c;
                total_next = chunk_c + HDR_BYTES;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (cks_done)
                begin
                    cks_next   = cks_val;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!hdr_stall)
                begin
                    if (final_reg || idx_reg == IDX_LAST)
                        state_next = ST_IDLE;
                    else
                    begin
                        // advance to the next fragment
                        remain_next = remain_reg - {5'd0, chunk_reg};
                        offs_next   = offs_reg + {5'd0, chunk_reg};
                        idx_next    = idx_reg + 6'd1;
                        state_next  = ST_CALC;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        hdr.fragment_index  = idx_reg;
        hdr.frag_offset     = offs_reg[LEN_W-1:3];
        hdr.total_len       = total_reg;
        hdr.more_fragments  = mf_reg;
        hdr.header_checksum = cks_reg;
        hdr.last            = final_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fps_reg   <= FPS_RESET;
            ttl_reg   <= TTL_RESET;
        end
        else
        begin
            state_reg <= state_next;
            fps_reg   <= fps_next;
            ttl_reg   <= ttl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg   <= desc_next;
        remain_reg <= remain_next;
        offs_reg   <= offs_next;
        idx_reg    <= idx_next;
        fs_reg     <= fs_next;
        chunk_reg  <= chunk_next;
        total_reg  <= total_next;
        mf_reg     <= mf_next;
        final_reg  <= final_next;
        cks_reg    <= cks_next;
    end

endmodule

`default_nettype wire

[rtl/core/ifhg_checker.sv]
// ----------------------------------------------------------------------------
// ifhg_checker
// Port-level checks on the fragment header generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ifhg_checker
(
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           desc_valid,
    input wire logic           desc_stall,
    input wire logic           hdr_valid,
    input wire logic           hdr_stall,
    input wire ifhg_pkg::hdr_t hdr,
    input wire logic           cfg_we
);
    import ifhg_pkg::*;

    // a waiting header item holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid && hdr_stall |=> hdr_valid && $stable(hdr))
        else $error("header item changed while stalled");

    // no new descriptor is taken while headers are pending
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid |-> desc_stall)
        else $error("descriptor channel open while header pending");

    // an accepted item is not answered with a header at once, and the descriptor channel stays stalled
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid && !desc_stall |=> !hdr_valid && desc_stall)
        else $error("header appeared right after acceptance");

    // only the final fragment clears more-fragments
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid |-> (hdr.last == !hdr.more_fragments) && (hdr.total_len >= HDR_BYTES))
        else $error("inconsistent last/more_fragments or length");

    // the user must write the registers only while the block is idle; the block itself does not enforce it
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> !desc_stall)
        else $error("register written while a datagram is in flight");

endmodule

bind ipv4_fragment_header_generator_unit ifhg_checker u_ifhg_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (desc_valid),
    .desc_stall (desc_stall),
    .hdr_valid  (hdr_valid),
    .hdr_stall  (hdr_stall),
    .hdr        (hdr),
    .cfg_we     (cfg_we)
);

`default_nettype wire
